// ----- rtl/tcw_pkg.sv -----
`timescale 1ns / 1ps

package tcw_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = ROWS * COLUMNS;
    localparam int ADDR_W  = $clog2(CELLS);
    localparam int PROW_W  = $clog2(ROWS);

    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int CHAR_W = 8;

    localparam int TAB_STOP = 8;

    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
    localparam logic [CHAR_W-1:0] CH_NULL      = 8'h00;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef struct packed {
        logic              op;
        logic [CHAR_W-1:0] char_code;
        logic              last_in_burst;
        logic [ROW_W-1:0]  read_row;
        logic [COL_W-1:0]  read_col;
    } t_in_word;

    typedef struct packed {
        logic [COL_W-1:0]  cursor_col;
        logic [ROW_W-1:0]  cursor_row;
        logic              cursor_publish;
        logic [CHAR_W-1:0] read_char;
    } t_out_word;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [CHAR_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

    typedef struct packed {
        logic      valid;
        t_out_word data;
    } t_result;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_SCROLL
    } t_state;

    // map a screen row onto its place in the circular row buffer
    function automatic logic [PROW_W-1:0] phys_row(input logic [ROW_W-1:0] row,
                                                   input logic [PROW_W-1:0] base);
        logic [ROW_W:0] sum;
        sum = {1'b0, row} + (ROW_W+1)'(base);
        if (sum >= (ROW_W+1)'(ROWS)) begin
            sum = sum - (ROW_W+1)'(ROWS);
        end
        return PROW_W'(sum);
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [PROW_W-1:0] prow,
                                                    input logic [COL_W-1:0] col);
        return ADDR_W'(int'(prow) * COLUMNS + int'(col));
    endfunction

endpackage

// ----- rtl/tcw_grid_ram.sv -----
`timescale 1ns / 1ps

module tcw_grid_ram (
    input  logic                       i_clk,
    input  tcw_pkg::t_mem_req          i_req,
    output logic [tcw_pkg::CHAR_W-1:0] o_rdata
);
    import tcw_pkg::*;

    logic [CHAR_W-1:0] r_mem [CELLS];
    logic [CHAR_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/tcw_ctrl.sv -----
`timescale 1ns / 1ps

module tcw_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  tcw_pkg::t_in_word          i_in_data,
    input  logic                       i_out_free,
    output tcw_pkg::t_result           o_res,
    output tcw_pkg::t_mem_req          o_mem,
    input  logic [tcw_pkg::CHAR_W-1:0] i_rdata
);
    import tcw_pkg::*;

    localparam logic [COL_W:0] TAB_ADD  = (COL_W+1)'(TAB_STOP);
    localparam logic [COL_W:0] TAB_MASK = (COL_W+1)'(TAB_STOP - 1);

    t_state             r_state, n_state;
    logic [COL_W-1:0]   r_col, n_col;
    logic [ROW_W-1:0]   r_row, n_row;
    logic [PROW_W-1:0]  r_base, n_base;
    logic [ADDR_W-1:0]  r_sweep, n_sweep;
    logic [ADDR_W-1:0]  r_sweep_end, n_sweep_end;
    logic               r_rd_oob, n_rd_oob;

    logic               accept;
    logic [COL_W:0]     c1;
    logic [ROW_W:0]     r1;
    logic               st_en;
    logic [COL_W-1:0]   st_col;
    logic [CHAR_W-1:0]  st_val;
    logic               scroll;
    logic               rd_in_range;

    assign accept     = (r_state == ST_IDLE) && i_out_free && i_in_valid;
    assign o_in_stall = !((r_state == ST_IDLE) && i_out_free);

    // cursor update for one character
    always_comb begin
        c1     = {1'b0, r_col};
        r1     = {1'b0, r_row};
        st_en  = 1'b0;
        st_col = r_col;
        st_val = i_in_data.char_code;
        case (i_in_data.char_code)
            CH_NEWLINE: begin
                c1 = '0;
                r1 = r1 + 1'b1;
            end
            CH_TAB: begin
                c1 = c1 + TAB_ADD - (c1 & TAB_MASK);
            end
            CH_BACKSPACE: begin
                if (r_col != '0) begin
                    c1     = c1 - 1'b1;
                    st_en  = 1'b1;
                    st_col = r_col - 1'b1;
                    st_val = CH_NULL;
                end
            end
            default: begin
                st_en = 1'b1;
                c1    = c1 + 1'b1;
            end
        endcase
        if (c1 >= (COL_W+1)'(COLUMNS)) begin
            c1 = '0;
            r1 = r1 + 1'b1;
        end
        scroll = (r1 >= (ROW_W+1)'(ROWS));
        if (scroll) begin
            r1 = (ROW_W+1)'(ROWS - 1);
        end
    end

    assign rd_in_range = (i_in_data.read_row < ROW_W'(ROWS)) &&
                         (i_in_data.read_col < COL_W'(COLUMNS));

    always_comb begin
        n_state     = r_state;
        n_col       = r_col;
        n_row       = r_row;
        n_base      = r_base;
        n_sweep     = r_sweep;
        n_sweep_end = r_sweep_end;
        n_rd_oob    = r_rd_oob;
        o_mem       = '0;
        o_res       = '0;
        case (r_state)
            ST_CLEAR, ST_SCROLL: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_sweep;
                o_mem.wdata = CH_SPACE;
                n_sweep     = r_sweep + 1'b1;
                if (r_sweep == r_sweep_end) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    if (i_in_data.op == OP_WRITE) begin
                        o_mem.we    = st_en;
                        o_mem.waddr = cell_addr(phys_row(r_row, r_base), st_col);
                        o_mem.wdata = st_val;
                        n_col       = c1[COL_W-1:0];
                        n_row       = r1[ROW_W-1:0];
                        o_res.valid                = 1'b1;
                        o_res.data.cursor_col      = c1[COL_W-1:0];
                        o_res.data.cursor_row      = r1[ROW_W-1:0];
                        o_res.data.cursor_publish  = i_in_data.last_in_burst;
                        o_res.data.read_char       = CH_NULL;
                        if (scroll) begin
                            // old top row becomes the new bottom row: blank it
                            n_base      = (r_base == PROW_W'(ROWS - 1)) ? '0 : r_base + 1'b1;
                            n_sweep     = cell_addr(r_base, '0);
                            n_sweep_end = cell_addr(r_base, COL_W'(COLUMNS - 1));
                            n_state     = ST_SCROLL;
                        end
                    end else begin
                        o_mem.re    = rd_in_range;
                        o_mem.raddr = cell_addr(phys_row(i_in_data.read_row, r_base),
                                                i_in_data.read_col);
                        n_rd_oob    = !rd_in_range;
                        n_state     = ST_READ;
                    end
                end
            end
            ST_READ: begin
                o_res.valid               = 1'b1;
                o_res.data.cursor_col     = r_col;
                o_res.data.cursor_row     = r_row;
                o_res.data.cursor_publish = 1'b0;
                o_res.data.read_char      = r_rd_oob ? CH_NULL : i_rdata;
                n_state                   = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_col       <= '0;
            r_row       <= '0;
            r_base      <= '0;
            r_sweep     <= '0;
            r_sweep_end <= ADDR_W'(CELLS - 1);
            r_rd_oob    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_col       <= n_col;
            r_row       <= n_row;
            r_base      <= n_base;
            r_sweep     <= n_sweep;
            r_sweep_end <= n_sweep_end;
            r_rd_oob    <= n_rd_oob;
        end
    end

endmodule

// ----- rtl/text_console_writer.sv -----
// Write word: result word registered the cycle after accept; one write per cycle sustained
// while the output is free. Read word: the grid RAM read is registered, then ST_READ builds
// the result; no new word is taken in ST_READ. A write that scrolls blanks the recycled
// bottom row: input stalls in ST_SCROLL. Reset (synchronous, active low) zeroes the cursor
// and row offset, then sweeps the whole grid RAM to spaces, one cell a cycle; input stalls.
`timescale 1ns / 1ps

module text_console_writer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  tcw_pkg::t_in_word   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output tcw_pkg::t_out_word  o_out_data
);
    import tcw_pkg::*;

    t_result           w_res;
    t_mem_req          w_mem;
    logic [CHAR_W-1:0] w_rdata;
    logic              w_out_free;

    logic              r_out_valid;
    t_out_word         r_out_data;

    assign w_out_free = !r_out_valid || !i_out_stall;

    tcw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_out_free (w_out_free),
        .o_res      (w_res),
        .o_mem      (w_mem),
        .i_rdata    (w_rdata)
    );

    tcw_grid_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (w_mem),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res.valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res.valid) begin
            r_out_data <= w_res.data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef NO_ASSERTIONS
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res.valid |-> !(r_out_valid && i_out_stall))
        else $error("result word overwrites a pending output word");

    a_write_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in_data.op == OP_WRITE) |=> o_out_valid)
        else $error("write word produced no result word");

    a_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in_data.op == OP_READ) |=> (o_in_stall ##1 o_out_valid))
        else $error("read word not held off or no result word");
`endif

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import tcw_pkg::*;

    // the reset sweep and a scroll both stall the input; allow a wide margin
    localparam int STALL_LIMIT = 10000;
    localparam int QUIET_TAIL  = 150;
    localparam int RANDOM_WORDS = 1400;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_word  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_word o_out_data;

    t_in_word  pending_words[$];
    t_out_word expected_cursor[$];

    logic [CHAR_W-1:0] screen [ROWS][COLUMNS];
    int unsigned cur_col;
    int unsigned cur_row;

    int  mismatches = 0;
    int  in_gap = 0;
    int  stall_left = 0;
    int  idle_cycles = 0;
    t_out_word want;

    text_console_writer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic void screen_scroll();
        for (int r = 0; r < ROWS - 1; r++) begin
            for (int c = 0; c < COLUMNS; c++) begin
                screen[r][c] = screen[r+1][c];
            end
        end
        for (int c = 0; c < COLUMNS; c++) begin
            screen[ROWS-1][c] = CH_SPACE;
        end
    endfunction

    // apply one word to the shadow console and queue the word it produces
    function automatic void console_apply(input t_in_word w);
        t_out_word r;
        r = '0;
        if (w.op == OP_WRITE) begin
            if (w.char_code == CH_NEWLINE) begin
                cur_col = 0;
                cur_row++;
            end else if (w.char_code == CH_TAB) begin
                cur_col += TAB_STOP - (cur_col % TAB_STOP);
            end else if (w.char_code == CH_BACKSPACE) begin
                // backspace at column 0 is dropped
                if (cur_col != 0) begin
                    cur_col--;
                    screen[cur_row][cur_col] = CH_NULL;
                end
            end else begin
                screen[cur_row][cur_col] = w.char_code;
                cur_col++;
            end
            if (cur_col >= COLUMNS) begin
                cur_col = 0;
                cur_row++;
            end
            if (cur_row >= ROWS) begin
                screen_scroll();
                cur_row = ROWS - 1;
            end
            r.cursor_publish = w.last_in_burst;
        end else if (w.read_row < ROWS && w.read_col < COLUMNS) begin
            r.read_char = screen[w.read_row][w.read_col];
        end
        r.cursor_col = COL_W'(cur_col);
        r.cursor_row = ROW_W'(cur_row);
        expected_cursor.push_back(r);
    endfunction

    function automatic string word_str(input t_out_word w);
        return $sformatf("col=%0d row=%0d pub=%0d char=%02h", w.cursor_col, w.cursor_row,
                         w.cursor_publish, w.read_char);
    endfunction

    function automatic void push_write(input logic [CHAR_W-1:0] ch, input logic last);
        t_in_word w;
        w.op            = OP_WRITE;
        w.char_code     = ch;
        w.last_in_burst = last;
        w.read_row      = ROW_W'($urandom);
        w.read_col      = COL_W'($urandom);
        pending_words.push_back(w);
    endfunction

    function automatic void push_read(input int row, input int col);
        t_in_word w;
        w.op            = OP_READ;
        w.char_code     = CHAR_W'($urandom);
        w.last_in_burst = 1'($urandom);
        w.read_row      = ROW_W'(row);
        w.read_col      = COL_W'(col);
        pending_words.push_back(w);
    endfunction

    function automatic logic [CHAR_W-1:0] pick_char();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 70) return CHAR_W'($urandom_range(8'h21, 8'h7e));
        if (sel < 80) return CHAR_W'($urandom_range(0, 255));
        if (sel < 86) return CH_TAB;
        if (sel < 92) return CH_BACKSPACE;
        if (sel < 96) return CH_SPACE;
        return CH_NEWLINE;
    endfunction

    initial begin
        int unsigned burst_len;
        int unsigned sel;
        int unsigned reads;

        for (int r = 0; r < ROWS; r++) begin
            for (int c = 0; c < COLUMNS; c++) begin
                screen[r][c] = CH_SPACE;
            end
        end
        cur_col = 0;
        cur_row = 0;

        // grid corners and cells off the grid
        push_read(0, 0);
        push_read(ROWS - 1, COLUMNS - 1);
        push_read(ROWS, 0);
        push_read(0, COLUMNS);
        push_read(31, 127);
        // backspace at the left edge, extreme bytes, backspace storing a null
        push_write(CH_BACKSPACE, 1'b1);
        push_write(8'h00, 1'b0);
        push_write(8'hff, 1'b1);
        push_write(CH_BACKSPACE, 1'b0);
        push_read(0, 0);
        push_read(0, 1);
        push_write(8'h41, 1'b1);
        push_write(CH_NEWLINE, 1'b0);
        // tabs until the cursor wraps off the last column
        for (int i = 0; i < COLUMNS / TAB_STOP; i++) begin
            push_write(CH_TAB, i == COLUMNS / TAB_STOP - 1);
        end

        // text bursts ended by last_in_burst, with reads between them
        while (pending_words.size() < RANDOM_WORDS) begin
            burst_len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 100)
                                                    : $urandom_range(1, 20);
            for (int i = 0; i < burst_len; i++) begin
                if (i == burst_len - 1 && $urandom_range(0, 1) == 0) begin
                    push_write(CH_NEWLINE, 1'b1);
                end else begin
                    push_write(pick_char(), i == burst_len - 1);
                end
            end
            if ($urandom_range(0, 9) < 4) begin
                reads = $urandom_range(1, 4);
                for (int i = 0; i < reads; i++) begin
                    sel = $urandom_range(0, 99);
                    if (sel < 50) begin
                        push_read($urandom_range(ROWS - 5, ROWS - 1),
                                  $urandom_range(0, COLUMNS - 1));
                    end else if (sel < 85) begin
                        push_read($urandom_range(0, ROWS - 1), $urandom_range(0, COLUMNS - 1));
                    end else begin
                        push_read($urandom_range(0, 31), $urandom_range(0, 127));
                    end
                end
            end
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_words.size() == 0 && !i_in_valid);
        wait (expected_cursor.size() == 0);
        repeat (20) @(posedge i_clk);
        @(negedge i_clk);
        if (mismatches == 0) begin
            $display("text_console_writer: match");
        end else begin
            $display("text_console_writer: mismatch");
        end
        $finish;
    end

    // input side: hold a stalled word, idle in random bursts until the tail
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                console_apply(i_in_data);
            end
            if (!i_in_valid || !o_in_stall) begin
                if (in_gap > 0) begin
                    in_gap--;
                    i_in_valid <= 1'b0;
                end else if (pending_words.size() == 0) begin
                    i_in_valid <= 1'b0;
                end else if (pending_words.size() > QUIET_TAIL
                             && $urandom_range(0, 15) == 0) begin
                    in_gap = $urandom_range(0, 9);
                    i_in_valid <= 1'b0;
                end else begin
                    i_in_data  <= pending_words.pop_front();
                    i_in_valid <= 1'b1;
                end
            end
        end
    end

    // output side: check each word against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_cursor.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("output word with nothing expected: %s",
                                 word_str(o_out_data));
                    end
                end else begin
                    want = expected_cursor.pop_front();
                    if (o_out_data.cursor_col !== want.cursor_col
                        || o_out_data.cursor_row !== want.cursor_row
                        || o_out_data.cursor_publish !== want.cursor_publish
                        || o_out_data.read_char !== want.read_char) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("output word mismatch: expected %s, got %s",
                                     word_str(want), word_str(o_out_data));
                        end
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if (pending_words.size() > QUIET_TAIL && $urandom_range(0, 15) == 0) begin
                stall_left = $urandom_range(0, 9);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("text_console_writer: mismatch");
                $finish;
            end
        end
    end

endmodule

// ----- files.f -----
rtl/tcw_pkg.sv
rtl/tcw_grid_ram.sv
rtl/tcw_ctrl.sv
rtl/text_console_writer.sv
tb/tb_top.sv
